// File: hdl/k_stacks_shared_buffer_unit_macros.svh
// Assertion macros shared by the shared-buffer stack unit modules.
`ifndef K_STACKS_SHARED_BUFFER_UNIT_MACROS_SVH
`define K_STACKS_SHARED_BUFFER_UNIT_MACROS_SVH

// Checked at every clock edge outside reset.
`define KSB_ASSERT(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Checked at every clock edge, reset included.
`define KSB_ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) (expr)) else $error(msg);

`endif

// File: hdl/ksb_pkg.sv
// Shared types and constants of the shared-buffer stack unit.
package ksb_pkg;

   // Default sizes.
   localparam int DEPTH_DEF  = 256;
   localparam int STACKS_DEF = 8;

   // Field widths.
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 3;

   // Operation codes.
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   // Value returned by a pop on an empty stack.
   localparam logic [DATA_W-1:0] POP_EMPTY_VALUE = '1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;         // latch the incoming word
      logic link_at_top;    // link read address follows the stack top
      logic push_fin;       // complete a push, load result
      logic pop_fin;        // complete a pop, load result
      logic underflow_fin;  // report pop on an empty stack
   } ksb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_pop;
      logic top_null;
   } ksb_stat_type;

endpackage

// File: hdl/k_stacks_shared_buffer_unit.sv
// Top level of the shared-buffer stack unit.
// STACKS stacks share DEPTH slots through a free list chained by per-slot
// links. Each accepted word is a push or pop on one stack and yields one
// response word. A push or an underflowing pop reaches the result register
// from the stack-top state, and a successful pop from the pop state that
// follows it, as set by the dependent registered reads: the stack top first,
// then the link and data of that slot. One operation is in flight at a time;
// a new word is taken at the edge after the previous one has reached the
// result register. An operation that finds the result register still held
// waits in place and the input stalls with it. No clearing pass follows
// reset: a fill count stands in for the initial link chain, and the unit
// accepts words as soon as reset is released.
module k_stacks_shared_buffer_unit
   import ksb_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEF,
   parameter int STACKS = STACKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // push_value[31:0]
   input  logic [3:0]  req_tuser,   // func[0], stack_index[3:1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pop_value[31:0]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   ksb_cmd_type  cmd;
   ksb_stat_type stat;

   ksb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ksb_datapath #(.DEPTH(DEPTH), .STACKS(STACKS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_tuser[0]),
      .req_stack_index (req_tuser[3:1]),
      .req_push_value  (req_tdata),
      .rsp_pop_value   (rsp_tdata),
      .rsp_status      (rsp_tuser)
   );

endmodule

// File: hdl/ksb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
module ksb_ram
   import ksb_pkg::*;
#(
   parameter int WIDTH = DATA_W,
   parameter int DEPTH = DEPTH_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: hdl/ksb_ctrl.sv
// Controller state machine of the shared-buffer stack unit.
`include "k_stacks_shared_buffer_unit_macros.svh"
module ksb_ctrl
   import ksb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  ksb_stat_type stat,
   output ksb_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TOP  = 2'd1;
   localparam logic [1:0] ST_POP  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       load_out;

   // The result register can take a word when empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      cmd.accept        = req_tvalid && req_tready;
      cmd.link_at_top   = ((state_ff == ST_TOP) && stat.is_pop) || (state_ff == ST_POP);
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in = ST_TOP;
            end
         end
         ST_TOP: begin
            if (!stat.is_pop) begin
               if (out_free) begin
                  cmd.push_fin = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (stat.top_null) begin
               if (out_free) begin
                  cmd.underflow_fin = 1'b1;
                  state_in          = ST_IDLE;
               end
            end else begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (out_free) begin
               cmd.pop_fin = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign load_out = cmd.push_fin || cmd.pop_fin || cmd.underflow_fin;

   // Result valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `KSB_ASSERT(a_accept_to_top, cmd.accept |=> state_ff == ST_TOP, "accept did not start an operation")
   `KSB_ASSERT(a_pop_state_nonempty, state_ff == ST_POP |-> stat.is_pop && !stat.top_null, "pop read on empty stack")
   `KSB_ASSERT(a_one_finish, $onehot0({cmd.push_fin, cmd.pop_fin, cmd.underflow_fin}), "two completions at once")
   `KSB_ASSERT(a_finish_leaves_room, load_out |=> rsp_valid_ff, "completed word not held")

endmodule

// File: hdl/ksb_datapath.sv
// Datapath of the shared-buffer stack unit: slot stores, stack tops, free list.
`include "k_stacks_shared_buffer_unit_macros.svh"
module ksb_datapath
   import ksb_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEF,
   parameter int STACKS = STACKS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ksb_cmd_type         cmd,
   output ksb_stat_type        stat,
   input  logic                req_func,
   input  logic [INDEX_W-1:0]  req_stack_index,
   input  logic [DATA_W-1:0]   req_push_value,
   output logic [DATA_W-1:0]   rsp_pop_value,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);
   localparam int SW = (STACKS > 1) ? $clog2(STACKS) : 1;
   localparam int INDEX_N = 2 ** INDEX_W;
   localparam logic [LW-1:0] NULL_SLOT = LW'(DEPTH);

   logic              func_ff;
   logic [SW-1:0]     sel_ff, sel_in, sel_req;
   logic [DATA_W-1:0] value_ff;
   logic [LW-1:0]     free_head_ff, free_head_in;
   logic [LW-1:0]     fresh_ff, fresh_in;
   logic [STACKS-1:0] top_vld_ff, top_vld_in;
   logic [DATA_W-1:0] pop_value_ff;
   logic [STATUS_W-1:0] status_ff;

   logic [LW-1:0]     top_q, top_eff, link_q, link_slot, link_eff;
   logic [DATA_W-1:0] data_q;
   logic              head_null, top_null, push_ok;
   logic              top_wr_en, link_wr_en, data_wr_en;
   logic [LW-1:0]     top_wr_data, link_wr_data;
   logic [AW-1:0]     link_wr_addr;

   // Stack index wraps onto the configured number of stacks through a small table.
   always_comb begin
      sel_req = '0;
      for (int i = 0; i < INDEX_N; i++) begin
         if (req_stack_index == INDEX_W'(i)) begin
            sel_req = SW'(i % STACKS);
         end
      end
   end

   assign sel_in  = cmd.accept ? sel_req : sel_ff;

   // A stack that was never written is empty.
   assign top_eff   = top_vld_ff[sel_ff] ? top_q : NULL_SLOT;
   assign head_null = (free_head_ff >= NULL_SLOT);
   assign top_null  = (top_eff >= NULL_SLOT);
   assign push_ok   = cmd.push_fin && !head_null;

   // Slots at or above the fill count were never linked and point to the next one.
   assign link_slot = cmd.link_at_top ? top_eff : free_head_ff;
   assign link_eff  = (link_slot >= fresh_ff) ? LW'(link_slot + 1'b1) : link_q;

   assign stat.is_pop    = (func_ff == FUNC_POP);
   assign stat.top_null  = top_null;

   // Store writes for a completing push or pop.
   assign top_wr_en    = push_ok || cmd.pop_fin;
   assign top_wr_data  = push_ok ? free_head_ff : link_eff;
   assign link_wr_en   = push_ok || cmd.pop_fin;
   assign link_wr_addr = push_ok ? free_head_ff[AW-1:0] : top_eff[AW-1:0];
   assign link_wr_data = push_ok ? top_eff : free_head_ff;
   assign data_wr_en   = push_ok;

   ksb_ram #(.WIDTH(LW), .DEPTH(STACKS)) u_top_ram (
      .clock   (clock),
      .wr_en   (top_wr_en),
      .wr_addr (sel_ff),
      .wr_data (top_wr_data),
      .rd_addr (sel_in),
      .rd_data (top_q)
   );

   ksb_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (link_slot[AW-1:0]),
      .rd_data (link_q)
   );

   ksb_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (free_head_ff[AW-1:0]),
      .wr_data (value_ff),
      .rd_addr (top_eff[AW-1:0]),
      .rd_data (data_q)
   );

   // Free list head, fill count and stack valid bits.
   always_comb begin
      free_head_in = free_head_ff;
      fresh_in     = fresh_ff;
      top_vld_in   = top_vld_ff;
      if (push_ok) begin
         free_head_in       = link_eff;
         top_vld_in[sel_ff] = 1'b1;
         if (free_head_ff == fresh_ff) begin
            fresh_in = LW'(fresh_ff + 1'b1);
         end
      end else if (cmd.pop_fin) begin
         free_head_in = top_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         fresh_ff     <= '0;
         top_vld_ff   <= '0;
      end else begin
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         top_vld_ff   <= top_vld_in;
      end
   end

   // Operation word and result registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff  <= req_func;
         sel_ff   <= sel_req;
         value_ff <= req_push_value;
      end
      if (cmd.push_fin) begin
         pop_value_ff <= '0;
         status_ff    <= head_null ? STATUS_OVERFLOW : STATUS_OK;
      end else if (cmd.pop_fin) begin
         pop_value_ff <= data_q;
         status_ff    <= STATUS_OK;
      end else if (cmd.underflow_fin) begin
         pop_value_ff <= POP_EMPTY_VALUE;
         status_ff    <= STATUS_UNDERFLOW;
      end
   end

   assign rsp_pop_value = pop_value_ff;
   assign rsp_status    = status_ff;

   `KSB_ASSERT(a_head_in_range, free_head_ff <= NULL_SLOT, "free list head out of range")
   `KSB_ASSERT(a_fresh_in_range, fresh_ff <= NULL_SLOT, "fill count out of range")
   `KSB_ASSERT(a_head_below_fill, push_ok |-> free_head_ff <= fresh_ff, "free list skipped a fresh slot")
   `KSB_ASSERT(a_pop_written, cmd.pop_fin |-> top_eff < fresh_ff, "pop of a slot never pushed")

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the shared-buffer stack unit: directed and random push/pop words.
module tb_top;
   import ksb_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int STACKS      = STACKS_DEF;
   localparam int LINK_W      = $clog2(DEPTH) + 1;
   localparam int NULL_SLOT   = DEPTH;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 20;
   localparam int RUN_LIMIT   = 5_000_000;

   // One response word as the unit should produce it.
   typedef struct packed {
      logic [DATA_W-1:0]   value;
      logic [STATUS_W-1:0] status;
   } stack_result_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic [31:0]         req_tdata  = '0;
   logic [3:0]          req_tuser  = '0;
   logic                rsp_tready = 1'b0;
   logic                req_tready;
   logic                rsp_tvalid;
   logic [31:0]         rsp_tdata;
   logic [1:0]          rsp_tuser;

   // Shadow copy of the slot store, the links and the stack tops.
   logic [DATA_W-1:0]   slot_value [DEPTH];
   logic [LINK_W-1:0]   slot_below [DEPTH];
   logic [LINK_W-1:0]   top_slot   [STACKS];
   logic [LINK_W-1:0]   free_slot;
   int                  stack_depth [STACKS];
   int                  slots_used;

   stack_result_type    pending_results [$];
   int                  error_count   = 0;
   bit                  gaps_on       = 1'b1;
   int                  hold_requests = 0;
   int                  holds_served  = 0;
   int                  hold_left     = 0;

   k_stacks_shared_buffer_unit #(
      .DEPTH  (DEPTH),
      .STACKS (STACKS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // push_value[31:0]
      .req_tuser  (req_tuser),   // func[0], stack_index[3:1]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // pop_value[31:0]
      .rsp_tuser  (rsp_tuser)    // status[1:0]
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every slot starts on the free list in order, and every stack starts empty.
   function void clear_stacks();
      for (int i = 0; i < DEPTH; i++) begin
         slot_value[i] = '0;
         slot_below[i] = LINK_W'(i + 1);
      end
      for (int s = 0; s < STACKS; s++) begin
         top_slot[s]    = LINK_W'(NULL_SLOT);
         stack_depth[s] = 0;
      end
      free_slot  = '0;
      slots_used = 0;
   endfunction

   // Applies one push or pop to the shadow state and returns the response word.
   function automatic stack_result_type apply_stack_op(logic func, logic [INDEX_W-1:0] idx,
                                                        logic [DATA_W-1:0] value);
      stack_result_type  res;
      logic [LINK_W-1:0] slot;
      res.value  = '0;
      res.status = STATUS_OK;
      if (func == FUNC_PUSH) begin
         slot = free_slot;
         if (slot >= NULL_SLOT) begin
            res.status = STATUS_OVERFLOW;
         end else begin
            free_slot        = slot_below[slot];
            slot_below[slot] = top_slot[idx];
            top_slot[idx]    = slot;
            slot_value[slot] = value;
            stack_depth[idx]++;
            slots_used++;
         end
      end else begin
         slot = top_slot[idx];
         if (slot >= NULL_SLOT) begin
            res.value  = POP_EMPTY_VALUE;
            res.status = STATUS_UNDERFLOW;
         end else begin
            res.value        = slot_value[slot];
            top_slot[idx]    = slot_below[slot];
            slot_below[slot] = free_slot;
            free_slot        = slot;
            stack_depth[idx]--;
            slots_used--;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   // Offers one word, waits for it to be taken and records its expected response.
   task automatic send_op(logic func, logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] value);
      if (gaps_on && $urandom_range(0, 99) < 16) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= {idx, func};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(apply_stack_op(func, idx, value));
   endtask

   task automatic send_random_op(int push_pct);
      logic func;
      func = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
      send_op(func, INDEX_W'($urandom_range(0, STACKS - 1)), $urandom);
   endtask

   // Pops on empty stacks at both ends of the index range.
   task automatic test_empty_pops();
      send_op(FUNC_POP, INDEX_W'(0), $urandom);
      send_op(FUNC_POP, INDEX_W'(STACKS - 1), $urandom);
   endtask

   // Extreme values pushed and popped back in reverse order, including an all-ones value
   // that must come back with an ok status, unlike an underflow.
   task automatic test_extreme_values();
      send_op(FUNC_PUSH, INDEX_W'(0), 32'h8000_0000);
      send_op(FUNC_PUSH, INDEX_W'(7), 32'h7FFF_FFFF);
      send_op(FUNC_PUSH, INDEX_W'(3), 32'hFFFF_FFFF);
      send_op(FUNC_PUSH, INDEX_W'(3), 32'h0000_0000);
      send_op(FUNC_PUSH, INDEX_W'(5), 32'h5555_AAAA);
      send_op(FUNC_PUSH, INDEX_W'(5), 32'hAAAA_5555);
      send_op(FUNC_POP,  INDEX_W'(3), 32'h1234_5678);
      send_op(FUNC_POP,  INDEX_W'(3), 32'h0);
      send_op(FUNC_POP,  INDEX_W'(3), 32'hFFFF_FFFF);
      send_op(FUNC_POP,  INDEX_W'(5), 32'h0);
      send_op(FUNC_POP,  INDEX_W'(0), 32'h0);
      send_op(FUNC_PUSH, INDEX_W'(5), 32'h0000_0001);
      send_op(FUNC_POP,  INDEX_W'(7), 32'h0);
      send_op(FUNC_POP,  INDEX_W'(5), 32'h0);
      send_op(FUNC_POP,  INDEX_W'(5), 32'h0);
   endtask

   // Uses up every slot, then pushes into the full store.
   task automatic test_fill_and_overflow();
      while (slots_used < DEPTH)
         send_op(FUNC_PUSH, INDEX_W'($urandom_range(0, STACKS - 1)), $urandom);
      repeat (6)
         send_op(FUNC_PUSH, INDEX_W'($urandom_range(0, STACKS - 1)), $urandom);
      // One slot freed and taken again, then full once more.
      send_op(FUNC_POP, INDEX_W'(2), $urandom);
      send_op(FUNC_PUSH, INDEX_W'(6), $urandom);
      send_op(FUNC_PUSH, INDEX_W'(6), $urandom);
   endtask

   // Empties every stack, with one extra pop each, and no idling on either side.
   task automatic test_drain_all();
      gaps_on = 1'b0;
      for (int s = 0; s < STACKS; s++) begin
         while (stack_depth[s] != 0)
            send_op(FUNC_POP, INDEX_W'(s), $urandom);
         send_op(FUNC_POP, INDEX_W'(s), $urandom);
      end
      gaps_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while words keep coming.
   task automatic test_backpressure();
      hold_requests <= hold_requests + 1;
      repeat (40) send_random_op(70);
   endtask

   // Random mix whose push share drifts so the store fills and drains.
   task automatic test_random_mix();
      int push_pct;
      push_pct = 50;
      for (int n = 0; n < 1150; n++) begin
         if (n % 100 == 0)
            push_pct = $urandom_range(15, 85);
         send_random_op(push_pct);
      end
   endtask

   // Receiver side: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= !(gaps_on && $urandom_range(0, 99) < 16);
      end
   end

   // Compares each response word with the oldest expectation.
   always @(posedge clock) begin : check_results
      stack_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 32'h0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.value)
               report_mismatch("pop_value", rsp_tdata, want.value);
            if (rsp_tuser !== want.status)
               report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
         end
      end
   end

   initial begin
      clear_stacks();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_pops();
      test_extreme_values();
      test_fill_and_overflow();
      test_drain_all();
      test_backpressure();
      test_random_mix();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("k_stacks_shared_buffer_unit test passed");
      else
         $display("k_stacks_shared_buffer_unit test failed");
      $finish;
   end

   // Run limit.
   initial begin
      #(RUN_LIMIT);
      $display("k_stacks_shared_buffer_unit test failed");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/ksb_pkg.sv
hdl/ksb_ram.sv
hdl/ksb_ctrl.sv
hdl/ksb_datapath.sv
hdl/k_stacks_shared_buffer_unit.sv
dv/tb_top.sv
